>>> rtl/core/isrc_pkg.sv
// Package: item types and constants for the interpolation search unit.
package isrc_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned IDX_W = 10;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] equal_above;
        logic [IDX_W-1:0] equal_below;
    } t_out_item;

    // divider request / response between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/core/isrc_ram.sv
// Generic single-port RAM with registered read.
module isrc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> rtl/core/isrc_div.sv
// Restoring divider, one quotient bit per cycle (unsigned 64 / 33).
module isrc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isrc_pkg::t_div_req  i_req,
    output isrc_pkg::t_div_rsp  o_rsp
);
    import isrc_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [33:0] r_rem, n_rem;
    logic [32:0] r_dvs, n_dvs;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] w_shift;
    logic [33:0] w_sub;

    assign w_shift = {r_rem[32:0], r_quo[63]};
    assign w_sub   = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[33]) begin
                n_rem = w_sub;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

>>> rtl/core/interpolation_search_with_run_count_unit.sv
// Interpolation search unit with equal-run count: top level.
// Write item: accepted with no result; also taken while a result waits.
// Search item: each probe reads lo and hi, divides, then reads and compares the probe;
//   run counting reads each neighbor in turn; a key outside the end keys returns without a divide.
// One search in flight; a search holds before its first probe while the previous
//   result is unaccepted. Reset (sync, active low) clears control and last_index.
module interpolation_search_with_run_count_unit #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  isrc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output isrc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [9:0]           i_cfg_data
);
    import isrc_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned PW = (AW > IDX_W) ? AW : IDX_W;  // index math width
    localparam logic [PW:0] LAST_MAX = (PW+1)'(TABLE_DEPTH - 1);
    localparam logic signed [PW+1:0] IDX_ONE = (PW+2)'(1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RDLO  = 12'b000000000010,  // issue read of lo
        S_RDHI  = 12'b000000000100,  // capture lo, issue read of hi
        S_CHK   = 12'b000000001000,  // capture hi, range checks
        S_DIV   = 12'b000000010000,  // wait for divide
        S_RDP   = 12'b000000100000,  // issue read of probe
        S_CMPP  = 12'b000001000000,  // wait read data
        S_EVAL  = 12'b000010000000,  // compare probe
        S_UPRD  = 12'b000100000000,  // run count up: issue read
        S_UPCMP = 12'b001000000000,
        S_DNRD  = 12'b010000000000,  // run count down
        S_DNCMP = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // table port
    logic                    w_we;
    logic [AW-1:0]           w_addr;
    logic signed [KEY_W-1:0] w_rdata;

    // search registers; signed with one spare bit so lo/hi can step past ends
    logic signed [PW+1:0] r_lo, n_lo, r_hi, n_hi, r_pos, n_pos, r_p, n_p;
    logic signed [PW+1:0] r_last, n_last;
    logic signed [KEY_W-1:0] r_key, n_key, r_vlo, n_vlo, r_vhi, n_vhi;
    logic [IDX_W-1:0] r_above, n_above, r_below, n_below;
    logic [IDX_W-1:0] r_cfg_last;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    logic [AW-1:0]    r_raddr, n_raddr;
    logic signed [KEY_W:0] w_dnum, w_dden;
    logic [PW:0]           w_span;
    logic [63:0]           w_prod;
    logic signed [PW+1:0]  w_probe;
    logic [63:0]           w_q;

    assign o_cfg_ready = (r_state == S_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_last <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg_last <= i_cfg_data;
        end
    end

    // a waiting result does not block: a new search holds in S_RDLO instead
    assign o_in_ready = (r_state == S_IDLE);

    isrc_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(i_in_item.key_value),
        .o_rdata(w_rdata)
    );

    // write port: only on accepted write items inside the table
    assign w_we = i_in_valid && o_in_ready && (i_in_item.req_type == REQ_WRITE)
                  && ({{(PW+1-IDX_W){1'b0}}, i_in_item.entry_index} <= LAST_MAX);
    assign w_addr = w_we ? AW'(i_in_item.entry_index) : n_raddr;

    // interpolation: (key - vlo) * (hi - lo) / (vhi - vlo); both non-negative
    assign w_dnum = {r_key[KEY_W-1], r_key} - {r_vlo[KEY_W-1], r_vlo};
    assign w_dden = {r_vhi[KEY_W-1], r_vhi} - {r_vlo[KEY_W-1], r_vlo};
    assign w_span = (PW+1)'(r_hi - r_lo);
    assign w_prod = 64'(w_dnum[KEY_W-1:0]) * 64'(w_span);
    assign w_q    = w_div_rsp.quotient;
    // quotient <= hi-lo when key <= vhi, so it fits
    assign w_probe = r_lo + (PW+2)'(w_q[PW:0]);

    isrc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_p         = r_p;
        n_last      = r_last;
        n_key       = r_key;
        n_vlo       = r_vlo;
        n_vhi       = r_vhi;
        n_above     = r_above;
        n_below     = r_below;
        n_raddr     = r_raddr;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_prod;
        w_div_req.divisor  = w_dden[KEY_W:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready && i_in_item.req_type == REQ_SEARCH) begin
                    n_key   = i_in_item.key_value;
                    n_lo    = '0;
                    n_pos   = '0;
                    n_above = '0;
                    n_below = '0;
                    if ({1'b0, (PW)'(r_cfg_last)} > LAST_MAX) begin
                        n_last = (PW+2)'(LAST_MAX);
                    end else begin
                        n_last = (PW+2)'(r_cfg_last);
                    end
                    n_hi    = n_last;
                    n_state = S_RDLO;
                end
            end
            S_RDLO: begin
                if (r_out_valid && !i_out_ready) begin
                    // previous result still waiting; output stays free after this
                    n_state = S_RDLO;
                end else if (r_lo < 0 || r_hi > r_last || r_lo > r_hi) begin
                    // loop guard on lo/hi bounds
                    n_state = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out = '0;
                end else begin
                    n_raddr = r_lo[AW-1:0];
                    n_state = S_RDHI;
                end
            end
            S_RDHI: begin
                n_raddr = r_hi[AW-1:0];
                n_state = S_CHK;
            end
            S_CHK: begin
                // data for lo arrived last cycle edge; hi arrives now
                n_state = S_DIV;
                if (r_state == S_CHK) begin
                    n_vhi = w_rdata;
                end
                if (r_key < r_vlo || r_key > w_rdata) begin
                    n_out_valid = 1'b1;
                    n_out = '0;
                    n_state = S_IDLE;
                end else if (r_lo == r_hi || w_rdata == r_vlo) begin
                    if (r_vlo == r_key) begin
                        n_pos   = r_lo;
                        n_p     = r_lo + IDX_ONE;
                        n_state = S_UPRD;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out = '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    w_div_req.dividend = w_prod;
                    w_div_req.divisor  = 33'({w_rdata[KEY_W-1], w_rdata}
                                             - {r_vlo[KEY_W-1], r_vlo});
                    w_div_req.start = 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_probe > r_hi) begin
                        n_pos = r_hi;
                    end else begin
                        n_pos = w_probe;
                    end
                    n_state = S_RDP;
                end
            end
            S_RDP: begin
                n_raddr = r_pos[AW-1:0];
                n_state = S_CMPP;
            end
            S_CMPP: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_rdata == r_key) begin
                    n_p     = r_pos + IDX_ONE;
                    n_state = S_UPRD;
                end else if ($signed(w_rdata) < r_key) begin
                    n_lo    = r_pos + IDX_ONE;
                    n_state = S_RDLO;
                end else begin
                    n_hi    = r_pos - IDX_ONE;
                    n_state = S_RDLO;
                end
            end
            S_UPRD: begin
                if (r_p > r_last) begin
                    n_p     = r_pos - IDX_ONE;
                    n_state = S_DNRD;
                end else begin
                    n_raddr = r_p[AW-1:0];
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                // data valid in the cycle after the read was issued
                if (w_rdata == r_key) begin
                    n_above = r_above + 1'b1;
                    n_p     = r_p + IDX_ONE;
                    n_state = S_UPRD;
                end else begin
                    n_p     = r_pos - IDX_ONE;
                    n_state = S_DNRD;
                end
            end
            S_DNRD: begin
                if (r_p < 0) begin
                    n_out_valid = 1'b1;
                    n_out.found       = 1'b1;
                    n_out.position    = r_pos[IDX_W-1:0];
                    n_out.equal_above = r_above;
                    n_out.equal_below = r_below;
                    n_state = S_IDLE;
                end else begin
                    n_raddr = r_p[AW-1:0];
                    n_state = S_DNCMP;
                end
            end
            S_DNCMP: begin
                if (w_rdata == r_key) begin
                    n_below = r_below + 1'b1;
                    n_p     = r_p - IDX_ONE;
                    n_state = S_DNRD;
                end else begin
                    n_out_valid = 1'b1;
                    n_out.found       = 1'b1;
                    n_out.position    = r_pos[IDX_W-1:0];
                    n_out.equal_above = r_above;
                    n_out.equal_below = r_below;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // vlo captured in S_RDHI, where the read of lo issued in S_RDLO returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_pos   <= n_pos;
        r_p     <= n_p;
        r_last  <= n_last;
        r_key   <= n_key;
        r_vlo   <= (r_state == S_RDHI) ? w_rdata : n_vlo;
        r_vhi   <= n_vhi;
        r_above <= n_above;
        r_below <= n_below;
        r_raddr <= n_raddr;
        r_out   <= n_out;
    end

    // RAM address is the next read address, so read data for an address set
    // in one state is visible in the following state.

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule
